FILE: rtl/bu2x_pkg.sv
package bu2x_pkg;

  localparam int unsigned DIM_W   = 12;
  localparam int unsigned COORD_W = 12;
  localparam logic [DIM_W-1:0] RESET_DIM = 12'd64;
  localparam int unsigned SLOT_COUNT = 9;

  typedef enum logic [0:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_e;

  // output slots of one source pixel: upper/middle/lower row, left/centre/right column
  typedef enum logic [3:0] {
    SLOT_UL = 4'd0,
    SLOT_UC = 4'd1,
    SLOT_UR = 4'd2,
    SLOT_ML = 4'd3,
    SLOT_MC = 4'd4,
    SLOT_MR = 4'd5,
    SLOT_LL = 4'd6,
    SLOT_LC = 4'd7,
    SLOT_LR = 4'd8
  } slot_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               run_last;
    logic               frame_done;
  } res_t;

  // the four source neighbours of the interpolation cell
  typedef struct packed {
    pix_t ul;
    pix_t up;
    pix_t left;
    pix_t cur;
  } nbr_t;

  function automatic logic [7:0] avg2_ch(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [7:0] avg4_ch(logic [7:0] a, logic [7:0] b,
                                         logic [7:0] c, logic [7:0] d);
    logic [9:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return s[9:2];
  endfunction

  function automatic pix_t avg2(pix_t a, pix_t b);
    pix_t r;
    r.red_in   = avg2_ch(a.red_in, b.red_in);
    r.green_in = avg2_ch(a.green_in, b.green_in);
    r.blue_in  = avg2_ch(a.blue_in, b.blue_in);
    return r;
  endfunction

  function automatic pix_t avg4(pix_t a, pix_t b, pix_t c, pix_t d);
    pix_t r;
    r.red_in   = avg4_ch(a.red_in, b.red_in, c.red_in, d.red_in);
    r.green_in = avg4_ch(a.green_in, b.green_in, c.green_in, d.green_in);
    r.blue_in  = avg4_ch(a.blue_in, b.blue_in, c.blue_in, d.blue_in);
    return r;
  endfunction

endpackage

FILE: rtl/bu2x_pix_if.sv
interface bu2x_pix_if;
  logic             valid;
  logic             ready;
  bu2x_pkg::pix_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bu2x_res_if.sv
interface bu2x_res_if;
  logic             valid;
  logic             ready;
  bu2x_pkg::res_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bu2x_ram.sv
module bu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/bu2x_emit.sv
module bu2x_emit #(
  parameter int XW = 11,
  parameter int YW = 11
) (
  input  bu2x_pkg::nbr_t                  nbr_i,
  input  bu2x_pkg::slot_e                 slot_i,
  input  logic [XW-1:0]                   x_i,
  input  logic [YW-1:0]                   y_i,
  output bu2x_pkg::pix_t                  pix_o,
  output logic [bu2x_pkg::COORD_W-1:0]    col_o,
  output logic [bu2x_pkg::COORD_W-1:0]    row_o
);

  logic [XW+1:0] cx;
  logic [YW+1:0] cy;

  assign cx = {1'b0, x_i, 1'b0};
  assign cy = {1'b0, y_i, 1'b0};

  always_comb begin
    unique case (slot_i) inside
      bu2x_pkg::SLOT_UL: begin
        pix_o = bu2x_pkg::avg4(nbr_i.ul, nbr_i.up, nbr_i.left, nbr_i.cur);
      end
      bu2x_pkg::SLOT_UC, bu2x_pkg::SLOT_UR: begin
        pix_o = bu2x_pkg::avg2(nbr_i.up, nbr_i.cur);
      end
      bu2x_pkg::SLOT_ML, bu2x_pkg::SLOT_LL: begin
        pix_o = bu2x_pkg::avg2(nbr_i.left, nbr_i.cur);
      end
      default: begin
        pix_o = nbr_i.cur;
      end
    endcase
  end

  always_comb begin
    unique case (slot_i) inside
      bu2x_pkg::SLOT_UL, bu2x_pkg::SLOT_ML, bu2x_pkg::SLOT_LL: begin
        col_o = bu2x_pkg::COORD_W'(cx - (XW+2)'(1));
      end
      bu2x_pkg::SLOT_UC, bu2x_pkg::SLOT_MC, bu2x_pkg::SLOT_LC: begin
        col_o = bu2x_pkg::COORD_W'(cx);
      end
      default: begin
        col_o = bu2x_pkg::COORD_W'(cx + (XW+2)'(1));
      end
    endcase
  end

  always_comb begin
    unique case (slot_i) inside
      bu2x_pkg::SLOT_UL, bu2x_pkg::SLOT_UC, bu2x_pkg::SLOT_UR: begin
        row_o = bu2x_pkg::COORD_W'(cy - (YW+2)'(1));
      end
      bu2x_pkg::SLOT_ML, bu2x_pkg::SLOT_MC, bu2x_pkg::SLOT_MR: begin
        row_o = bu2x_pkg::COORD_W'(cy);
      end
      default: begin
        row_o = bu2x_pkg::COORD_W'(cy + (YW+2)'(1));
      end
    endcase
  end

endmodule

FILE: rtl/bilinear_upscale_2x_top.sv
// 2x bilinear upscaler for a stream of rgb source pixels in raster order. Each source
// pixel (x,y) yields one to nine output pixels, each tagged with its output column and
// row: rows 2y-1 (y>0), 2y and 2y+1 (last row only), and within each row columns 2x-1
// (x>0), 2x and 2x+1 (last column only), in that order; four on average. run_last marks
// the final output of a source pixel, frame_done the final output of a frame. An accepted
// pixel sits in the emit register until its outputs (one to nine) have moved, one output
// a cycle while the output register is free, into the output register, and the next pixel
// is taken in the cycle the last output of the current one moves out. The previous source
// row lives in a single line store of MAX_WIDTH words that is read and written once per
// accepted pixel; it needs no clearing after reset. Writing the width or height register
// restarts the frame and may only be done while the block is idle.
module bilinear_upscale_2x_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [bu2x_pkg::DIM_W-1:0]  cfg_data_i,
  bu2x_pix_if.sink                    pix_i,
  bu2x_res_if.source                  res_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  // configuration
  logic [bu2x_pkg::DIM_W-1:0] width_q, height_q;
  logic [XW:0]                w_eff;
  logic [YW:0]                h_eff;

  // source position and neighbour registers
  logic [XW-1:0]   col_q;
  logic [YW-1:0]   row_q;
  bu2x_pkg::pix_t  left_q, ul_q;

  // emit register: one source pixel with its pending output slots
  logic                               b_valid_q;
  logic [bu2x_pkg::SLOT_COUNT-1:0]    b_mask_q, b_mask_d;
  logic [XW-1:0]                      b_x_q;
  logic [YW-1:0]                      b_y_q;
  logic                               b_top_q;
  logic                               b_frame_q;
  bu2x_pkg::pix_t                     b_cur_q, b_left_q, b_ul_q;

  // output register
  logic            out_valid_q;
  bu2x_pkg::res_t  out_q;

  // current request position
  logic [XW-1:0]   x_a;
  logic [YW-1:0]   y_a;
  logic            last_col, last_row;
  logic [2:0]      row_ok, col_ok;
  logic [bu2x_pkg::SLOT_COUNT-1:0] mask_a;

  logic            in_fire, out_free, b_fire, b_last, b_done;
  logic [bu2x_pkg::SLOT_COUNT-1:0] low_bit;
  bu2x_pkg::slot_e slot;
  bu2x_pkg::pix_t  ram_rdata, up_b, emit_pix;
  bu2x_pkg::nbr_t  nbr;
  logic [bu2x_pkg::COORD_W-1:0] emit_col, emit_row;

  // out-of-range sizes: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = (XW+1)'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(width_q);
    end
    if (height_q == '0) begin
      h_eff = (YW+1)'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(height_q);
    end
  end

  // a stale counter beyond a shrunk size wraps to the frame start
  assign x_a = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
  assign y_a = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
  assign last_col = ({1'b0, x_a} == (w_eff - (XW+1)'(1)));
  assign last_row = ({1'b0, y_a} == (h_eff - (YW+1)'(1)));

  // rows: upper, middle, lower; columns: left, centre, right
  assign row_ok = {last_row, 1'b1, (y_a != '0)};
  assign col_ok = {last_col, 1'b1, (x_a != '0)};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_a[r*3+c] = row_ok[r] & col_ok[c];
      end
    end
  end

  // lowest pending slot goes out first
  assign low_bit = b_mask_q & (~b_mask_q + bu2x_pkg::SLOT_COUNT'(1));
  assign b_mask_d = b_mask_q & ~low_bit;
  assign b_last = (b_mask_d == '0);

  always_comb begin
    slot = bu2x_pkg::SLOT_UL;
    for (int s = bu2x_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
      if (b_mask_q[s]) begin
        slot = bu2x_pkg::slot_e'(4'(s));
      end
    end
  end

  // handshakes
  assign out_free = !out_valid_q || res_o.ready;
  assign b_fire   = b_valid_q && out_free;
  assign b_done   = b_fire && b_last;
  assign pix_i.ready = !b_valid_q || b_done;
  assign in_fire  = pix_i.valid && pix_i.ready;

  // line store: the word read at a request is the pixel above it
  bu2x_ram #(
    .WIDTH ($bits(bu2x_pkg::pix_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (x_a),
    .wdata_i (pix_i.data),
    .re_i    (in_fire),
    .raddr_i (x_a),
    .rdata_o (ram_rdata)
  );

  // top row has no pixel above
  assign up_b = b_top_q ? ram_rdata : '0;

  assign nbr.ul   = b_ul_q;
  assign nbr.up   = up_b;
  assign nbr.left = b_left_q;
  assign nbr.cur  = b_cur_q;

  bu2x_emit #(
    .XW (XW),
    .YW (YW)
  ) u_emit (
    .nbr_i  (nbr),
    .slot_i (slot),
    .x_i    (b_x_q),
    .y_i    (b_y_q),
    .pix_o  (emit_pix),
    .col_o  (emit_col),
    .row_o  (emit_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= bu2x_pkg::RESET_DIM;
      height_q    <= bu2x_pkg::RESET_DIM;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      ul_q        <= '0;
      b_valid_q   <= 1'b0;
      b_mask_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // emit register
      if (in_fire) begin
        b_valid_q <= 1'b1;
        b_mask_q  <= mask_a;
      end else if (b_fire) begin
        b_valid_q <= !b_last;
        b_mask_q  <= b_mask_d;
      end

      // the upper-left neighbour is the pixel above the previous request
      if (b_done) begin
        ul_q <= up_b;
      end

      if (in_fire) begin
        left_q <= pix_i.data;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : YW'({1'b0, y_a} + (YW+1)'(1));
        end else begin
          col_q <= XW'({1'b0, x_a} + (XW+1)'(1));
          row_q <= y_a;
        end
      end

      // a size write restarts the frame
      if (cfg_we_i) begin
        unique case (bu2x_pkg::reg_idx_e'(cfg_idx_i))
          bu2x_pkg::REG_SRC_WIDTH: begin
            width_q <= cfg_data_i;
          end
          bu2x_pkg::REG_SRC_HEIGHT: begin
            height_q <= cfg_data_i;
          end
        endcase
        col_q  <= '0;
        row_q  <= '0;
        left_q <= '0;
        ul_q   <= '0;
      end

      // output register
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_x_q     <= x_a;
      b_y_q     <= y_a;
      b_top_q   <= (y_a != '0);
      b_frame_q <= last_col && last_row;
      b_cur_q   <= pix_i.data;
      b_left_q  <= left_q;
      b_ul_q    <= b_valid_q ? up_b : ul_q;
    end
    if (b_fire) begin
      out_q.out_col    <= emit_col;
      out_q.out_row    <= emit_row;
      out_q.red_out    <= emit_pix.red_in;
      out_q.green_out  <= emit_pix.green_in;
      out_q.blue_out   <= emit_pix.blue_in;
      out_q.run_last   <= b_last;
      out_q.frame_done <= b_last && b_frame_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

FILE: rtl/bu2x_checker.sv
module bu2x_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            pix_valid_i,
  input logic            pix_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input bu2x_pkg::res_t  res_data_i
);

  logic       in_fire, last_fire;
  logic [1:0] pending_q;

  assign in_fire   = pix_valid_i && pix_ready_i;
  assign last_fire = res_valid_i && res_ready_i && res_data_i.run_last;

  // source pixels taken whose final output has not yet gone out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fire && !last_fire) begin
      pending_q <= pending_q + 2'd1;
    end else if (!in_fire && last_fire) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("more than two source pixels in flight");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd0 |-> !res_valid_i)
    else $error("output without an open source pixel");

  a_frame_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.frame_done |->
      res_data_i.run_last && res_data_i.out_col[0] && res_data_i.out_row[0])
    else $error("frame end not on the bottom-right output");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled output request changed");

endmodule

bind bilinear_upscale_2x_top bu2x_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

FILE: tb/bilinear_upscale_2x_top_tb.sv
`timescale 1ns / 100ps

module bilinear_upscale_2x_top_tb;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned MAX_H = 2048;
  localparam int unsigned RANDOM_PIXELS = 400;
  localparam int unsigned LONG_HOLD = 400;

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [bu2x_pkg::DIM_W-1:0] cfg_data;

  bu2x_pix_if pix_bus ();
  bu2x_res_if res_bus ();

  bilinear_upscale_2x_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix_bus),
    .res_o     (res_bus)
  );

  // source pixels waiting for the driver, and output pixels still owed by the block
  bu2x_pkg::pix_t pending_pix[$];
  bu2x_pkg::res_t awaited_px[$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken = 0;
  int unsigned mismatches = 0;
  logic pix_fire = 1'b0;

  // shadow of the block: size registers, line store, neighbour registers, position
  logic [bu2x_pkg::DIM_W-1:0] cfg_width = bu2x_pkg::RESET_DIM;
  logic [bu2x_pkg::DIM_W-1:0] cfg_height = bu2x_pkg::RESET_DIM;
  bu2x_pkg::pix_t row_mem [MAX_W];
  bu2x_pkg::pix_t left_px = '0;
  bu2x_pkg::pix_t ul_px = '0;
  int unsigned src_col = 0;
  int unsigned src_row = 0;

  // sender burst state and receiver stall pattern
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0] pat_pos = '0;
  int unsigned pat_age = 0;
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  // a size of zero acts as one, anything past the maximum as the maximum
  function automatic int unsigned clamp_dim(logic [bu2x_pkg::DIM_W-1:0] v,
                                            int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic logic [7:0] half_sum(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  function automatic logic [7:0] quarter_sum(logic [7:0] a, logic [7:0] b,
                                             logic [7:0] c, logic [7:0] d);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c) + 10'(d);
    return s[9:2];
  endfunction

  function automatic bu2x_pkg::pix_t mean2(bu2x_pkg::pix_t a, bu2x_pkg::pix_t b);
    bu2x_pkg::pix_t r;
    r.red_in   = half_sum(a.red_in, b.red_in);
    r.green_in = half_sum(a.green_in, b.green_in);
    r.blue_in  = half_sum(a.blue_in, b.blue_in);
    return r;
  endfunction

  function automatic bu2x_pkg::pix_t mean4(bu2x_pkg::pix_t a, bu2x_pkg::pix_t b,
                                           bu2x_pkg::pix_t c, bu2x_pkg::pix_t d);
    bu2x_pkg::pix_t r;
    r.red_in   = quarter_sum(a.red_in, b.red_in, c.red_in, d.red_in);
    r.green_in = quarter_sum(a.green_in, b.green_in, c.green_in, d.green_in);
    r.blue_in  = quarter_sum(a.blue_in, b.blue_in, c.blue_in, d.blue_in);
    return r;
  endfunction

  function automatic bu2x_pkg::res_t out_px(int unsigned col, int unsigned row,
                                            bu2x_pkg::pix_t p);
    bu2x_pkg::res_t r;
    r.out_col    = bu2x_pkg::COORD_W'(col);
    r.out_row    = bu2x_pkg::COORD_W'(row);
    r.red_out    = p.red_in;
    r.green_out  = p.green_in;
    r.blue_out   = p.blue_in;
    r.run_last   = 1'b0;
    r.frame_done = 1'b0;
    return r;
  endfunction

  // outputs owed for one accepted source pixel, in emission order:
  // row above (not on the top row), own row, row below (bottom row only);
  // within a row: left column (not on the first column), own, right (last column only)
  task automatic predict_upscale(input bu2x_pkg::pix_t cur);
    int unsigned w, h, x, y, cx, ry;
    bu2x_pkg::pix_t up;
    bit lc, lr;
    bu2x_pkg::res_t outs [bu2x_pkg::SLOT_COUNT];
    int n;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_H);
    x = (src_col >= w) ? 0 : src_col;
    y = (src_row >= h) ? 0 : src_row;
    up = (y > 0) ? row_mem[x] : '0;
    lc = (x == w - 1);
    lr = (y == h - 1);
    cx = 2 * x;
    ry = 2 * y;
    n = 0;
    if (y > 0) begin
      if (x > 0) begin
        outs[n] = out_px(cx - 1, ry - 1, mean4(ul_px, up, left_px, cur));
        n++;
      end
      outs[n] = out_px(cx, ry - 1, mean2(up, cur));
      n++;
      if (lc) begin
        outs[n] = out_px(cx + 1, ry - 1, mean2(up, cur));
        n++;
      end
    end
    if (x > 0) begin
      outs[n] = out_px(cx - 1, ry, mean2(left_px, cur));
      n++;
    end
    outs[n] = out_px(cx, ry, cur);
    n++;
    if (lc) begin
      outs[n] = out_px(cx + 1, ry, cur);
      n++;
    end
    if (lr) begin
      if (x > 0) begin
        outs[n] = out_px(cx - 1, ry + 1, mean2(left_px, cur));
        n++;
      end
      outs[n] = out_px(cx, ry + 1, cur);
      n++;
      if (lc) begin
        outs[n] = out_px(cx + 1, ry + 1, cur);
        n++;
      end
    end
    outs[n-1].run_last = 1'b1;
    outs[n-1].frame_done = lc && lr;
    for (int i = 0; i < n; i++) awaited_px.push_back(outs[i]);
    // advance the shadow state; the frame wraps after its last pixel
    row_mem[x] = cur;
    ul_px = up;
    left_px = cur;
    if (lc) begin
      src_col = 0;
      src_row = lr ? 0 : y + 1;
    end else begin
      src_col = x + 1;
      src_row = y;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // monitor: checks output requests against the oldest owed pixel, then
  // predicts the outputs of any source request taken at the same edge
  always @(posedge clk_i) begin
    bu2x_pkg::res_t got, want;
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.data;
        if (awaited_px.size() == 0) begin
          report_mismatch("unexpected output, col", 32'(got.out_col), 0);
        end else begin
          want = awaited_px.pop_front();
          if (got.out_col !== want.out_col)
            report_mismatch("out_col", 32'(got.out_col), 32'(want.out_col));
          if (got.out_row !== want.out_row)
            report_mismatch("out_row", 32'(got.out_row), 32'(want.out_row));
          if (got.red_out !== want.red_out)
            report_mismatch("red_out", 32'(got.red_out), 32'(want.red_out));
          if (got.green_out !== want.green_out)
            report_mismatch("green_out", 32'(got.green_out), 32'(want.green_out));
          if (got.blue_out !== want.blue_out)
            report_mismatch("blue_out", 32'(got.blue_out), 32'(want.blue_out));
          if (got.run_last !== want.run_last)
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        end
      end
      if (pix_bus.valid && pix_bus.ready) begin
        predict_upscale(pix_bus.data);
        pixels_taken++;
      end
    end
    pix_fire <= rst_n && pix_bus.valid && pix_bus.ready;
  end

  // driver: bursts of source requests with random gaps, zero gaps now and then
  always @(negedge clk_i) begin
    if (!rst_n) begin
      pix_bus.valid <= 1'b0;
    end else if (pix_bus.valid && !pix_fire) begin
      // request still waiting for ready, hold it
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      pix_bus.valid <= 1'b0;
    end else if (pending_pix.size() != 0) begin
      pix_bus.valid <= 1'b1;
      pix_bus.data <= pending_pix.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      pix_bus.valid <= 1'b0;
    end
  end

  // receiver: ready follows a rotating 16-bit stall mask, redrawn at random when its age counter runs out,
  // plus one long hold while the sender still has plenty queued
  always @(negedge clk_i) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      res_bus.ready <= 1'b0;
    end else if (!hold_done && pixels_taken > 40 && pending_pix.size() >= 8) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= stall_mask[pat_pos];
      pat_pos <= pat_pos + 4'd1;
      if (pat_age == 0) begin
        pat_age <= 63;
        case ($urandom_range(0, 3))
          0: stall_mask <= 16'hFFFF;
          1: stall_mask <= 16'($urandom) | 16'h1;
          2: stall_mask <= 16'($urandom) | 16'($urandom);
          default: stall_mask <= (16'($urandom) & 16'($urandom)) | 16'h1;
        endcase
      end else begin
        pat_age <= pat_age - 1;
      end
    end
  end

  // every source request taken and every owed output pixel received
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixels_taken != pixels_queued || awaited_px.size() != 0);
  endtask

  // size writes only while idle; each one restarts the frame
  task automatic write_reg(input bu2x_pkg::reg_idx_e idx,
                           input logic [bu2x_pkg::DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == bu2x_pkg::REG_SRC_WIDTH) cfg_width = val;
    else cfg_height = val;
    src_col = 0;
    src_row = 0;
    left_px = '0;
    ul_px = '0;
  endtask

  task automatic set_size(input logic [bu2x_pkg::DIM_W-1:0] w,
                          input logic [bu2x_pkg::DIM_W-1:0] h);
    wait_drained();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(bu2x_pkg::REG_SRC_WIDTH, w);
      write_reg(bu2x_pkg::REG_SRC_HEIGHT, h);
    end else begin
      write_reg(bu2x_pkg::REG_SRC_HEIGHT, h);
      write_reg(bu2x_pkg::REG_SRC_WIDTH, w);
    end
  endtask

  task automatic queue_pixel(input logic [23:0] rgb);
    pending_pix.push_back(bu2x_pkg::pix_t'(rgb));
    pixels_queued++;
  endtask

  // mostly small sizes; now and then zero or a large size that may lie past the maximum
  function automatic logic [bu2x_pkg::DIM_W-1:0] pick_dim(int unsigned lim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bu2x_pkg::DIM_W'($urandom_range(9, 4095));
      default: return bu2x_pkg::DIM_W'($urandom_range(1, lim));
    endcase
  endfunction

  initial begin
    int unsigned random_items, phase, count, area, split;
    logic [bu2x_pkg::DIM_W-1:0] w, h;
    clk_i = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = bu2x_pkg::REG_SRC_WIDTH;
    cfg_data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.data = '0;
    res_bus.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_n = 1'b1;

    // directed: reset sizes first, no write yet
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);
    queue_pixel(24'h80FF01);

    // 2x2 frame: last pixel produces all nine outputs, rounding at the extremes
    set_size(12'd2, 12'd2);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000100);
    queue_pixel(24'hFF0001);
    queue_pixel(24'h7F80FE);

    // single-pixel frames, zero sizes act as one
    set_size(12'd1, 12'd1);
    queue_pixel(24'h010203);
    queue_pixel(24'hFEFDFC);
    set_size(12'd0, 12'd0);
    queue_pixel(24'hAA55AA);

    // sizes past the maximum clamp to it, maximum itself
    set_size(12'hFFF, 12'hFFF);
    queue_pixel(24'h00FF00);
    queue_pixel(24'hFF00FF);
    queue_pixel(24'h123456);
    set_size(12'd2048, 12'd2);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);

    // single column and a non-square frame
    set_size(12'd1, 12'd3);
    queue_pixel(24'hFF8000);
    queue_pixel(24'h0080FF);
    queue_pixel(24'h01FE7F);
    set_size(12'd3, 12'd2);
    for (int i = 0; i < 6; i++) queue_pixel(24'($urandom));

    // random frames, some ending mid-frame, several frames per setting
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_PIXELS) begin
      w = pick_dim(8);
      h = pick_dim(5);
      area = clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H);
      if (area <= 40)
        count = area * $urandom_range(1, 2) + $urandom_range(0, clamp_dim(w, MAX_W));
      else
        count = $urandom_range(5, 40);
      if (phase == 0 && count < 30) count = 30;
      set_size(w, h);
      // sender pause mid-frame until everything owed has come back
      split = (phase == 1 || $urandom_range(0, 3) == 0) ? count / 2 : count;
      for (int i = 0; i < count; i++) begin
        if (i == split && i != 0) wait_drained();
        queue_pixel(24'($urandom));
      end
      random_items += count;
      phase++;
    end

    wait_drained();
    // allow stray outputs to show up before the verdict
    repeat (30) @(negedge clk_i);
    if (mismatches == 0 && awaited_px.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
